// File: rtl/ptb_pkg.sv
// Shared types and constants for the periodic timer bank.
`timescale 1ns / 1ps

package ptb_pkg;

    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 32;
    localparam int SIG_W    = 16;
    localparam int TGT_W    = 6;
    localparam int MAX_SLOTS = 2 ** SLOT_W;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_ARM    = 2'd1,
        MODE_DISARM = 2'd2,
        MODE_BIND   = 2'd3
    } mode_t;

    // Command broadcast to every cell; the per-cell select travels apart.
    typedef struct packed {
        logic               tick;
        logic               arm;
        logic               disarm;
        logic               bind_slot;
        logic [COUNT_W-1:0] timeout;
        logic [COUNT_W-1:0] reload;
        logic [SIG_W-1:0]   sig;
        logic [TGT_W-1:0]   tgt;
    } cell_cmd_t;

endpackage

// File: rtl/ptb_if.sv
// Valid/ready channel interfaces for the timer bank command and event words.
`timescale 1ns / 1ps

interface ptb_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     mode;
    logic [ptb_pkg::SLOT_W-1:0]     slot;
    logic [ptb_pkg::COUNT_W-1:0]    timeout_ticks;
    logic [ptb_pkg::COUNT_W-1:0]    reload_ticks;
    logic [ptb_pkg::SIG_W-1:0]      signal_id;
    logic [ptb_pkg::TGT_W-1:0]      target_id;

    modport source (output valid, mode, slot, timeout_ticks, reload_ticks, signal_id,
                    target_id, input ready);
    modport sink (input valid, mode, slot, timeout_ticks, reload_ticks, signal_id,
                  target_id, output ready);
    modport monitor (input valid, ready, mode, slot, timeout_ticks, reload_ticks,
                     signal_id, target_id);
endinterface

interface ptb_out_if;
    logic                           valid;
    logic                           ready;
    logic [ptb_pkg::SLOT_W-1:0]     expired_slot;
    logic [ptb_pkg::SIG_W-1:0]      event_signal;
    logic [ptb_pkg::TGT_W-1:0]      event_target;
    logic                           last;

    modport source (output valid, expired_slot, event_signal, event_target, last,
                    input ready);
    modport sink (input valid, expired_slot, event_signal, event_target, last,
                  output ready);
    modport monitor (input valid, ready, expired_slot, event_signal, event_target, last);
endinterface

// File: rtl/periodic_timer_bank.sv
// Periodic timer bank top level: a row of slot cells swept by a scan token.
// Arm, disarm and bind words apply on the accept edge; ready stays high after
// them. A tick word counts down every bound, running slot on the accept edge,
// then a token walks the row one cell per cycle, held on a hit cell while the
// event register is full. Event words leave through the event register.
// Reset (rst_n low, async) unbinds every slot, clears counts and the scan.
`timescale 1ns / 1ps

module periodic_timer_bank #(
    parameter int NUM_SLOTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    ptb_in_if.sink       cmd,
    ptb_out_if.source    rsp
);

    // Slot field is four bits wide, so at most MAX_SLOTS cells are reachable.
    localparam int NCELL = (NUM_SLOTS < ptb_pkg::MAX_SLOTS) ? NUM_SLOTS
                                                             : ptb_pkg::MAX_SLOTS;

    logic busy_reg, busy_next;
    logic out_valid_reg;
    logic [ptb_pkg::SLOT_W-1:0] out_slot_reg;
    logic [ptb_pkg::SIG_W-1:0]  out_sig_reg;
    logic [ptb_pkg::TGT_W-1:0]  out_tgt_reg;
    logic                       out_last_reg;

    logic accept, tick_go, wr_go;
    logic shift, advance, emit, out_free;
    ptb_pkg::cell_cmd_t cell_cmd;

    logic [NCELL:0]   token_chain;
    logic [NCELL:0]   later_chain;
    logic [NCELL-1:0] sel;
    logic [NCELL-1:0] hit;
    logic [NCELL-1:0] last_hit;
    logic [ptb_pkg::SIG_W-1:0] cell_sig [NCELL];
    logic [ptb_pkg::TGT_W-1:0] cell_tgt [NCELL];

    logic                       cur_hit;
    logic                       cur_last;
    logic [ptb_pkg::SLOT_W-1:0] cur_slot;
    logic [ptb_pkg::SIG_W-1:0]  cur_sig;
    logic [ptb_pkg::TGT_W-1:0]  cur_tgt;

    // only idle accepts; a tick word holds ready low until the sweep ends
    assign cmd.ready = ~busy_reg;
    assign accept    = cmd.valid & cmd.ready;
    assign tick_go   = accept & (cmd.mode == ptb_pkg::MODE_TICK);
    assign wr_go     = accept & (cmd.mode != ptb_pkg::MODE_TICK);

    always_comb
    begin
        cell_cmd.tick      = tick_go;
        cell_cmd.arm       = wr_go & (cmd.mode == ptb_pkg::MODE_ARM);
        cell_cmd.disarm    = wr_go & (cmd.mode == ptb_pkg::MODE_DISARM);
        cell_cmd.bind_slot = wr_go & (cmd.mode == ptb_pkg::MODE_BIND);
        cell_cmd.timeout   = cmd.timeout_ticks;
        cell_cmd.reload    = cmd.reload_ticks;
        cell_cmd.sig       = cmd.signal_id;
        cell_cmd.tgt       = cmd.target_id;
    end

    // token enters cell 0 on the tick accept; later_chain is the suffix OR of
    // pending flags, so a hit with nothing pending behind it is the last word
    assign token_chain[0]     = tick_go;
    assign later_chain[NCELL] = 1'b0;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        assign sel[i] = cmd.slot == ptb_pkg::SLOT_W'(i);

        ptb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cell_cmd),
            .sel       (sel[i]),
            .shift     (shift),
            .emit      (emit),
            .token_in  (token_chain[i]),
            .token_out (token_chain[i+1]),
            .later_in  (later_chain[i+1]),
            .later_out (later_chain[i]),
            .hit       (hit[i]),
            .last_hit  (last_hit[i]),
            .sig       (cell_sig[i]),
            .tgt       (cell_tgt[i])
        );
    end

    // token is one-hot, so the hit record is a plain OR across the row
    always_comb
    begin
        cur_slot = '0;
        cur_sig  = '0;
        cur_tgt  = '0;
        for (int i = 0; i < NCELL; i++)
        begin
            if (hit[i])
            begin
                cur_slot = cur_slot | ptb_pkg::SLOT_W'(i);
                cur_sig  = cur_sig | cell_sig[i];
                cur_tgt  = cur_tgt | cell_tgt[i];
            end
        end
    end

    assign cur_hit  = |hit;
    assign cur_last = |last_hit;

    // the token waits on a hit cell until the event register can take it
    assign out_free = ~out_valid_reg | rsp.ready;
    assign emit     = cur_hit & out_free;
    assign advance  = busy_reg & (~cur_hit | out_free);
    assign shift    = advance | tick_go;

    always_comb
    begin
        busy_next = busy_reg;
        priority if (tick_go)
            busy_next = 1'b1;
        else if (advance && token_chain[NCELL])
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_slot_reg <= cur_slot;
            out_sig_reg  <= cur_sig;
            out_tgt_reg  <= cur_tgt;
            out_last_reg <= cur_last;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.expired_slot = out_slot_reg;
    assign rsp.event_signal = out_sig_reg;
    assign rsp.event_target = out_tgt_reg;
    assign rsp.last         = out_last_reg;

endmodule

// File: rtl/ptb_cell.sv
// One timer slot: counts, binding, expiry flag and the scan token stage.
`timescale 1ns / 1ps

module ptb_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ptb_pkg::cell_cmd_t           cmd,
    input  logic                         sel,
    input  logic                         shift,
    input  logic                         emit,
    input  logic                         token_in,
    output logic                         token_out,
    input  logic                         later_in,
    output logic                         later_out,
    output logic                         hit,
    output logic                         last_hit,
    output logic [ptb_pkg::SIG_W-1:0]    sig,
    output logic [ptb_pkg::TGT_W-1:0]    tgt
);

    logic [ptb_pkg::COUNT_W-1:0] remaining_reg, remaining_next;
    logic [ptb_pkg::COUNT_W-1:0] reload_reg, reload_next;
    logic                        bound_reg, bound_next;
    logic                        pending_reg, pending_next;
    logic                        token_reg, token_next;
    logic [ptb_pkg::SIG_W-1:0]   sig_reg;
    logic [ptb_pkg::TGT_W-1:0]   tgt_reg;

    always_comb
    begin
        remaining_next = remaining_reg;
        reload_next    = reload_reg;
        bound_next     = bound_reg;
        pending_next   = pending_reg;
        token_next     = shift ? token_in : token_reg;

        if (cmd.bind_slot && sel)
        begin
            bound_next     = 1'b1;
            remaining_next = '0;
            reload_next    = '0;
        end
        else if (cmd.arm && sel && bound_reg)
        begin
            remaining_next = cmd.timeout;
            reload_next    = cmd.reload;
        end
        else if (cmd.disarm && sel && bound_reg)
        begin
            remaining_next = '0;
        end
        else if (cmd.tick && bound_reg && remaining_reg != '0)
        begin
            // expiry when the count is one at a tick; it reloads instead of reaching zero
            if (remaining_reg == ptb_pkg::COUNT_W'(1))
                remaining_next = reload_reg;
            else
                remaining_next = remaining_reg - ptb_pkg::COUNT_W'(1);
        end

        if (cmd.tick)
            pending_next = bound_reg && remaining_reg == ptb_pkg::COUNT_W'(1);
        else if (emit && token_reg)
            pending_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            reload_reg    <= '0;
            bound_reg     <= 1'b0;
            pending_reg   <= 1'b0;
            token_reg     <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            reload_reg    <= reload_next;
            bound_reg     <= bound_next;
            pending_reg   <= pending_next;
            token_reg     <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bind_slot && sel)
        begin
            sig_reg <= cmd.sig;
            tgt_reg <= cmd.tgt;
        end
    end

    assign token_out = token_reg;
    assign later_out = pending_reg | later_in;
    assign hit       = token_reg & pending_reg;
    assign last_hit  = hit & ~later_in;
    assign sig       = sig_reg;
    assign tgt       = tgt_reg;

endmodule

// File: rtl/ptb_checker.sv
// Port-level checks for the periodic timer bank, bound to the top level.
`timescale 1ns / 1ps

module ptb_checker (
    input  logic         clk,
    input  logic         rst_n,
    ptb_in_if.sink       cmd,
    ptb_out_if.source    rsp
);

    logic cmd_acc;
    logic tick_acc;

    assign cmd_acc  = cmd.valid & cmd.ready;
    assign tick_acc = cmd_acc & (cmd.mode == ptb_pkg::MODE_TICK);

    // stalled event word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.expired_slot)
            && $stable(rsp.event_signal) && $stable(rsp.last))
        else $error("event word changed while stalled");

    // a tick word blocks the command side during its sweep
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc |=> !cmd.ready)
        else $error("command accepted right after a tick");

    // arm, disarm and bind never produce an event
    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc && !tick_acc && !rsp.valid |=> !rsp.valid)
        else $error("event after a non-tick word");

    // first event of a tick waits behind the decrement and the token register
    a_tick_lat: assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc && !rsp.valid |=> !rsp.valid)
        else $error("event too soon after tick");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
);
